FILE: hdl/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// Depends on nothing; used by the parser, the result register, the top level and the testbench.
package wsd_pkg;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD       = 2'd0;
   localparam logic [1:0] KIND_EMPTY_FRAME   = 2'd1;
   localparam logic [1:0] KIND_HEADER_REJECT = 2'd2;
   localparam logic [1:0] KIND_OPCODE_REJECT = 2'd3;

   // Frame layout
   localparam int unsigned DEFAULT_BUFFER_BYTES = 128;
   localparam int unsigned HEADER_BYTES         = 2;
   localparam int unsigned KEY_BYTES            = 4;
   localparam int unsigned PREAMBLE_BYTES       = HEADER_BYTES + KEY_BYTES;

   localparam logic [7:0] FIN_BIT       = 8'h80;
   localparam logic [7:0] MASK_BIT      = 8'h80;
   localparam logic [7:0] OPCODE_BITS   = 8'h0f;
   localparam logic [7:0] LENGTH_BITS   = 8'h7f;
   localparam logic [3:0] OPCODE_BINARY = 4'd2;

   localparam int unsigned POS_WIDTH = 7;
   localparam int unsigned LEN_WIDTH = 7;

   // One result beat
   typedef struct packed {
      logic [1:0]           kind;
      logic [7:0]           payload_byte;
      logic                 last;
      logic [LEN_WIDTH-1:0] frame_length;
   } result_type;

endpackage

FILE: hdl/wsd_in_reg.sv
// Input register for received bytes of the WebSocket frame deframer.
// Depends on no other file; holds one byte until the parser takes it.
module wsd_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   output logic       held_valid,
   output logic [7:0] held_byte,
   input  logic       take
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   // Accept a new beat when empty or when the held byte moves on this cycle
   assign in_ready   = !valid_ff || take;
   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on accept
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
      end
   end

endmodule

FILE: hdl/wsd_parser.sv
// Frame parser: header capture and check, mask key, payload unmasking.
// Depends on wsd_pkg for layout constants, result kinds and result_type.
module wsd_parser #(
   parameter int unsigned BUFFER_BYTES = wsd_pkg::DEFAULT_BUFFER_BYTES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   output logic                result_valid,
   output wsd_pkg::result_type result
);

   localparam int unsigned PW = wsd_pkg::POS_WIDTH;
   localparam int unsigned LW = wsd_pkg::LEN_WIDTH;
   localparam logic [LW-1:0] MAX_LENGTH = LW'(BUFFER_BYTES - wsd_pkg::PREAMBLE_BYTES);
   localparam logic [PW-1:0] POS_LEN_BYTE = PW'(1);
   localparam logic [PW-1:0] POS_LAST_KEY = PW'(wsd_pkg::PREAMBLE_BYTES - 1);
   localparam logic [PW-1:0] POS_PAYLOAD  = PW'(wsd_pkg::PREAMBLE_BYTES);

   logic [PW-1:0] position_ff, position_in;
   logic [7:0]    first_byte_ff, first_byte_in;
   logic [LW-1:0] length_ff, length_in;
   logic          mask_bit_ff, mask_bit_in;
   logic [7:0]    key_ff [4];
   logic          key_we;
   logic [1:0]    key_sel;
   logic          halted_ff, halted_in;

   logic [PW-1:0] index;
   logic [7:0]    first_byte_now;
   logic [LW-1:0] length_now;
   logic          mask_bit_now;
   logic          header_bad;
   logic          opcode_bad;
   logic          final_byte;

   assign index = position_ff - POS_PAYLOAD;

   always_comb begin
      position_in   = position_ff;
      first_byte_in = first_byte_ff;
      length_in     = length_ff;
      mask_bit_in   = mask_bit_ff;
      halted_in     = halted_ff;
      key_we        = 1'b0;
      key_sel       = position_ff[1:0] - 2'd2;
      result_valid  = 1'b0;
      result        = '0;
      // Header fields as seen by the check, from the registered header bytes
      first_byte_now = first_byte_ff;
      length_now     = length_ff;
      mask_bit_now   = mask_bit_ff;
      header_bad     = ((first_byte_now & ~wsd_pkg::OPCODE_BITS) != wsd_pkg::FIN_BIT)
                       || (length_now > MAX_LENGTH) || !mask_bit_now;
      opcode_bad     = first_byte_now[3:0] != wsd_pkg::OPCODE_BINARY;
      final_byte     = ({1'b0, index} + 8'd1) >= {1'b0, length_ff};

      if (step && !halted_ff) begin
         if (position_ff < POS_PAYLOAD) begin
            // Preamble: capture header and key bytes
            if (position_ff == '0) begin
               first_byte_in = rx_byte;
            end else if (position_ff == POS_LEN_BYTE) begin
               length_in   = rx_byte[LW-1:0] & wsd_pkg::LENGTH_BITS[LW-1:0];
               mask_bit_in = |(rx_byte & wsd_pkg::MASK_BIT);
            end else begin
               key_we = 1'b1;
            end
            if (position_ff != POS_LAST_KEY) begin
               position_in = position_ff + PW'(1);
            end else if (header_bad) begin
               halted_in     = 1'b1;
               position_in   = '0;
               result_valid  = 1'b1;
               result.kind   = wsd_pkg::KIND_HEADER_REJECT;
            end else if (opcode_bad) begin
               halted_in     = 1'b1;
               position_in   = '0;
               result_valid  = 1'b1;
               result.kind   = wsd_pkg::KIND_OPCODE_REJECT;
            end else if (length_ff == '0) begin
               position_in   = '0;
               result_valid  = 1'b1;
               result.kind   = wsd_pkg::KIND_EMPTY_FRAME;
            end else begin
               position_in   = POS_PAYLOAD;
            end
         end else begin
            // Payload: unmask with the rotating key
            result_valid        = 1'b1;
            result.kind         = wsd_pkg::KIND_PAYLOAD;
            result.payload_byte = rx_byte ^ key_ff[index[1:0]];
            if (final_byte) begin
               position_in         = '0;
               result.last         = 1'b1;
               result.frame_length = length_ff;
            end else begin
               position_in = position_ff + PW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         first_byte_ff <= '0;
         length_ff     <= '0;
         mask_bit_ff   <= 1'b0;
         halted_ff     <= 1'b0;
      end else begin
         position_ff   <= position_in;
         first_byte_ff <= first_byte_in;
         length_ff     <= length_in;
         mask_bit_ff   <= mask_bit_in;
         halted_ff     <= halted_in;
      end
   end

   // Mask key bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '{default: 8'h00};
      end else if (key_we) begin
         key_ff[key_sel] <= rx_byte;
      end
   end

endmodule

FILE: hdl/wsd_out_reg.sv
// Result register of the WebSocket frame deframer.
// Depends on wsd_pkg for result_type; holds one beat until the sink takes it.
module wsd_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  wsd_pkg::result_type load_data,
   output logic                free,
   output logic                out_valid,
   input  logic                out_ready,
   output wsd_pkg::result_type out_data
);

   logic                valid_ff;
   logic                valid_in;
   wsd_pkg::result_type data_ff;

   // Slot frees when empty or drained this cycle
   assign free      = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (free) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload when a result arrives
   always_ff @(posedge clock) begin
      if (load && free) begin
         data_ff <= load_data;
      end
   end

endmodule

FILE: hdl/websocket_frame_deframer.sv
// WebSocket masked frame deframer, top level.
// Path: a byte is registered at input, parsed, and its result is held in the result register.
// Throughput: one byte per cycle while the result register is free; the parser steps only then.
// Reset: synchronous, active high; clears frame position, header, key and halt flag.
// Depends on wsd_pkg, wsd_in_reg, wsd_parser and wsd_out_reg.
module websocket_frame_deframer #(
   parameter int unsigned BUFFER_BYTES = wsd_pkg::DEFAULT_BUFFER_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] payload_byte, [14:8] frame_length, [15] zero
   output logic        rsp_tlast,   // last
   output logic [1:0]  rsp_tuser    // [1:0] kind
);

   logic                held_valid;
   logic [7:0]          held_byte;
   logic                slot_free;
   logic                step;
   logic                result_valid;
   wsd_pkg::result_type result;
   wsd_pkg::result_type out_data;

   // Advance the held byte when the result slot can take its result
   assign step = held_valid && slot_free;

   wsd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .held_valid (held_valid),
      .held_byte  (held_byte),
      .take       (step)
   );

   wsd_parser #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .rx_byte      (held_byte),
      .result_valid (result_valid),
      .result       (result)
   );

   wsd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (result_valid),
      .load_data (result),
      .free      (slot_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   // Pack the result beat
   assign rsp_tdata = {1'b0, out_data.frame_length, out_data.payload_byte};
   assign rsp_tlast = out_data.last;
   assign rsp_tuser = out_data.kind;

endmodule

FILE: test/testbench.sv
// Self-checking testbench for websocket_frame_deframer: drives masked frames byte by byte
// and checks every result beat against a cycle-free predictor of the deframer.
// Depends on wsd_pkg and the websocket_frame_deframer RTL.
module testbench;

   localparam int unsigned MAX_PAYLOAD =
      wsd_pkg::DEFAULT_BUFFER_BYTES - wsd_pkg::PREAMBLE_BYTES;
   localparam logic [7:0] HDR_BINARY = wsd_pkg::FIN_BIT | 8'(wsd_pkg::OPCODE_BINARY);
   localparam int TOTAL_BYTES   = 1920;
   localparam int STRETCH_BYTES = 200;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 20;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int GAP_PERCENT   = 13;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;

   // Predictor state
   logic [6:0] frame_pos    = '0;
   logic [7:0] header_first = '0;
   logic [6:0] header_len   = '0;
   logic       header_mask  = 1'b0;
   logic [7:0] key_bytes [4] = '{default: '0};
   logic       parser_halted = 1'b0;

   wsd_pkg::result_type deframed_results [$];
   wsd_pkg::result_type got_beat;
   wsd_pkg::result_type want_beat;

   int  failures = 0;
   int  bytes_sent = 0;
   int  cycle_count = 0;
   int  hold_off_cycles = 0;
   bit  sender_gaps = 1'b1;
   bit  receiver_gaps = 1'b1;

   websocket_frame_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Advance the deframer model by one byte; return 1 when the byte yields a result beat
   function automatic bit deframe_byte(input logic [7:0] rx,
                                       output wsd_pkg::result_type beat);
      logic [6:0] idx;
      beat = '0;
      if (parser_halted) return 1'b0;
      if (frame_pos < wsd_pkg::PREAMBLE_BYTES) begin
         case (frame_pos)
            7'd0: header_first = rx;
            7'd1: begin
               header_len  = rx[6:0];
               header_mask = rx[7];
            end
            default: key_bytes[frame_pos[1:0] - 2'd2] = rx;
         endcase
         if (frame_pos + 1 < wsd_pkg::PREAMBLE_BYTES) begin
            frame_pos = frame_pos + 7'd1;
            return 1'b0;
         end
         // Check the header on the last key byte
         frame_pos = '0;
         if ((header_first & ~wsd_pkg::OPCODE_BITS) != wsd_pkg::FIN_BIT
             || header_len > MAX_PAYLOAD || !header_mask) begin
            parser_halted = 1'b1;
            beat.kind = wsd_pkg::KIND_HEADER_REJECT;
            return 1'b1;
         end
         if (header_first[3:0] != wsd_pkg::OPCODE_BINARY) begin
            parser_halted = 1'b1;
            beat.kind = wsd_pkg::KIND_OPCODE_REJECT;
            return 1'b1;
         end
         if (header_len == 0) begin
            beat.kind = wsd_pkg::KIND_EMPTY_FRAME;
            return 1'b1;
         end
         frame_pos = 7'(wsd_pkg::PREAMBLE_BYTES);
         return 1'b0;
      end
      // Unmask a payload byte with the rotating key
      idx = frame_pos - 7'(wsd_pkg::PREAMBLE_BYTES);
      beat.kind = wsd_pkg::KIND_PAYLOAD;
      beat.payload_byte = rx ^ key_bytes[idx[1:0]];
      if (idx + 1 >= header_len) begin
         frame_pos = '0;
         beat.last = 1'b1;
         beat.frame_length = header_len;
      end else begin
         frame_pos = frame_pos + 7'd1;
      end
      return 1'b1;
   endfunction

   // Check each result beat, then predict from each accepted input beat
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_beat.kind         = rsp_tuser;
            got_beat.payload_byte = rsp_tdata[7:0];
            got_beat.last         = rsp_tlast;
            got_beat.frame_length = rsp_tdata[14:8];
            if (deframed_results.size() == 0) begin
               $display("%0t: unexpected beat kind=%0d byte=%02h last=%0b len=%0d", $time,
                        got_beat.kind, got_beat.payload_byte, got_beat.last,
                        got_beat.frame_length);
               failures++;
            end else begin
               want_beat = deframed_results.pop_front();
               if (got_beat.kind !== want_beat.kind
                   || got_beat.payload_byte !== want_beat.payload_byte
                   || got_beat.last !== want_beat.last
                   || got_beat.frame_length !== want_beat.frame_length) begin
                  $display({"%0t: mismatch expected kind=%0d byte=%02h last=%0b len=%0d,",
                            " got kind=%0d byte=%02h last=%0b len=%0d"},
                           $time, want_beat.kind, want_beat.payload_byte, want_beat.last,
                           want_beat.frame_length, got_beat.kind, got_beat.payload_byte,
                           got_beat.last, got_beat.frame_length);
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (deframe_byte(req_tdata, want_beat)) deframed_results.push_back(want_beat);
         end
      end
   end

   // Receiver: random stalls, or a counted hold-off when one is requested
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_off_cycles = hold_off_cycles - 1;
      end else begin
         rsp_tready <= !(receiver_gaps && $urandom_range(99) < GAP_PERCENT);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offer one byte and hold it until the block takes it
   task automatic send_byte(input logic [7:0] rx);
      while (sender_gaps && $urandom_range(99) < GAP_PERCENT) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // Send a well-formed binary frame; a negative fill means random payload
   task automatic send_frame(input logic [7:0] first_byte, input logic [6:0] len,
                             input logic [31:0] key, input int fill);
      send_byte(first_byte);
      send_byte(wsd_pkg::MASK_BIT | 8'(len));
      for (int k = 0; k < 4; k++) send_byte(key[8*k +: 8]);
      for (int k = 0; k < len; k++) send_byte(fill < 0 ? 8'($urandom) : fill[7:0]);
   endtask

   function automatic logic [6:0] pick_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) return 7'(MAX_PAYLOAD);
      if (roll < 15) return 7'($urandom_range(MAX_PAYLOAD));
      if (roll < 25) return 7'd0;
      return 7'($urandom_range(12, 1));
   endfunction

   // Empty frames, one-byte and two-byte frames with all-zero and all-one data and keys
   task automatic test_directed_frames();
      send_frame(HDR_BINARY, 7'd0, 32'h0000_0000, 0);
      send_frame(HDR_BINARY, 7'd1, 32'hFFFF_FFFF, 8'h00);
      send_frame(HDR_BINARY, 7'd2, 32'hFFFF_FFFF, 8'hFF);
      send_frame(HDR_BINARY, 7'd0, 32'hFFFF_FFFF, 0);
   endtask

   // Run frames with no idling on either side
   task automatic test_back_to_back();
      int stop_at;
      stop_at = bytes_sent + STRETCH_BYTES;
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      while (bytes_sent < stop_at) send_frame(HDR_BINARY, pick_length(), $urandom, -1);
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
   endtask

   // Hold off the receiver while the sender keeps pushing, so the block backs up
   task automatic test_backpressure();
      int stop_at;
      stop_at = bytes_sent + STRETCH_BYTES;
      sender_gaps = 1'b0;
      hold_off_cycles = HOLD_CYCLES;
      while (bytes_sent < stop_at) begin
         send_frame(HDR_BINARY, 7'($urandom_range(60, 20)), $urandom, -1);
      end
      sender_gaps = 1'b1;
   endtask

   // Random frames with random keys and payloads
   task automatic test_random_frames();
      while (bytes_sent < TOTAL_BYTES) send_frame(HDR_BINARY, pick_length(), $urandom, -1);
   endtask

   // One bad header (the block halts for good), then bytes that must be ignored
   task automatic test_rejection();
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      int op;
      first_byte  = HDR_BINARY;
      second_byte = wsd_pkg::MASK_BIT | 8'($urandom_range(MAX_PAYLOAD));
      case ($urandom_range(4))
         0: first_byte = 8'($urandom_range(7)) << 4 | 8'($urandom_range(15));
         1: first_byte = wsd_pkg::FIN_BIT | 8'($urandom_range(7, 1)) << 4
                         | 8'($urandom_range(15));
         2: second_byte = 8'($urandom_range(127));
         3: second_byte = wsd_pkg::MASK_BIT | 8'($urandom_range(127, MAX_PAYLOAD + 1));
         default: begin
            op = $urandom_range(14);
            if (op >= wsd_pkg::OPCODE_BINARY) op++;
            first_byte = wsd_pkg::FIN_BIT | 8'(op);
         end
      endcase
      send_byte(first_byte);
      send_byte(second_byte);
      for (int k = 0; k < 4 + 20; k++) send_byte(8'($urandom));
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      test_directed_frames();
      test_back_to_back();
      test_backpressure();
      test_random_frames();
      test_rejection();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (deframed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/wsd_pkg.sv
hdl/wsd_in_reg.sv
hdl/wsd_parser.sv
hdl/wsd_out_reg.sv
hdl/websocket_frame_deframer.sv
test/testbench.sv
